FILE: hdl/ikservo_pkg.sv
// Shared types, constants and angle table for the arm IK to servo pulse unit.
package ikservo_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS = 32;
	localparam int NORM_BITS = 40;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [63:0] RAD_Q30 = 64'd61520874802;

	typedef enum logic [2:0] {
		REG_PULSE_MIN = 3'd0,
		REG_PULSE_MAX = 3'd1,
		REG_ANGLE_SPAN = 3'd2,
		REG_UPPER_LEN = 3'd3,
		REG_LOWER_LEN = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [11:0] pulse_min;
		logic [11:0] pulse_max;
		logic [8:0] angle_span;
		logic [7:0] upper_link_length;
		logic [7:0] lower_link_length;
	} cfg_t;

	typedef struct packed {
		logic unreachable;
		logic signed [22:0] n;
		logic signed [22:0] m;
		logic [7:0] xabs;
		logic signed [7:0] y;
	} side_t;

	typedef struct packed {
		logic [39:0] db;
		logic [33:0] dc;
		side_t side;
	} work_t;

	// atan(2^-i) in degrees, Q30 internally, returned at frac fraction bits
	function automatic logic [63:0] step_angle(input int i, input int frac);
		logic [63:0] v;
		case (i)
			0: v = 64'd48318382080;
			1: v = 64'd28524006506;
			2: v = 64'd15071301663;
			3: v = 64'd7650428050;
			4: v = 64'd3840059795;
			5: v = 64'd1921901881;
			6: v = 64'd961185452;
			default: begin
				v = RAD_Q30 >> i;
				if (3 * i < 63) begin
					v = v - (RAD_Q30 >> (3 * i)) / 3;
				end
			end
		endcase
		return v >> (30 - frac);
	endfunction

endpackage

FILE: hdl/ikservo_front.sv
// Front end: squares, law-of-cosines terms, discriminants and reach check.
module ikservo_front
	import ikservo_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic signed [7:0] target_x,
	input logic signed [7:0] target_y,
	output logic out_valid,
	input logic out_ready,
	output work_t out_word
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [7:0] xabs_s1, xabs_s2, xabs_s3;
	logic signed [7:0] y_s1, y_s2, y_s3;
	logic [15:0] xsq_s1, ysq_s1, u2_s1, w2_s1;
	logic [15:0] s_s2, u2_s2, w2_s2;
	logic signed [22:0] n_s2, m_s2, n_s3, m_s3;
	logic zero_s2, zero_s3;
	logic [31:0] su_s3, uw_s3;
	logic [43:0] nn_s3, mm_s3;
	work_t word_s4;

	logic [7:0] xabs_w;
	logic [15:0] s_w;
	logic signed [22:0] n_w, m_w;
	logic signed [45:0] nn_w, mm_w, db_w, dc_w;

	assign en = !v_s4 || out_ready;
	assign in_ready = en;

	assign xabs_w = target_x[7] ? 8'(-target_x) : 8'(target_x);
	assign s_w = xsq_s1 + ysq_s1;
	assign n_w = $signed({1'b0, s_w, 6'b0}) + $signed({7'b0, u2_s1}) - $signed({7'b0, w2_s1});
	assign m_w = $signed({7'b0, u2_s1}) + $signed({7'b0, w2_s1}) - $signed({1'b0, s_w, 6'b0});
	assign nn_w = n_s2 * n_s2;
	assign mm_w = m_s2 * m_s2;
	assign db_w = $signed({6'b0, su_s3, 8'b0}) - $signed({2'b0, nn_s3});
	assign dc_w = $signed({12'b0, uw_s3, 2'b0}) - $signed({2'b0, mm_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xabs_s1 <= xabs_w;
			y_s1 <= target_y;
			xsq_s1 <= xabs_w * xabs_w;
			ysq_s1 <= 16'(target_y * target_y);
			u2_s1 <= cfg.upper_link_length * cfg.upper_link_length;
			w2_s1 <= cfg.lower_link_length * cfg.lower_link_length;

			xabs_s2 <= xabs_s1;
			y_s2 <= y_s1;
			s_s2 <= s_w;
			u2_s2 <= u2_s1;
			w2_s2 <= w2_s1;
			n_s2 <= n_w;
			m_s2 <= m_w;
			zero_s2 <= (s_w == '0) || (u2_s1 == '0) || (w2_s1 == '0);

			xabs_s3 <= xabs_s2;
			y_s3 <= y_s2;
			n_s3 <= n_s2;
			m_s3 <= m_s2;
			zero_s3 <= zero_s2;
			su_s3 <= s_s2 * u2_s2;
			uw_s3 <= u2_s2 * w2_s2;
			nn_s3 <= nn_w[43:0];
			mm_s3 <= mm_w[43:0];

			word_s4.db <= db_w[39:0];
			word_s4.dc <= dc_w[33:0];
			word_s4.side.unreachable <= zero_s3 || db_w[45] || dc_w[45];
			word_s4.side.n <= n_s3;
			word_s4.side.m <= m_s3;
			word_s4.side.xabs <= xabs_s3;
			word_s4.side.y <= y_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_word = word_s4;

endmodule

FILE: hdl/ikservo_queue.sv
// Short word queue between the front end and the back end.
module ikservo_queue
	import ikservo_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input work_t in_word,
	output logic out_valid,
	input logic out_ready,
	output work_t out_word
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	work_t mem_q [0:QUEUE_DEPTH-1];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, pop;

	assign in_ready = count_q != CW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_word;
		end
	end

endmodule

FILE: hdl/ikservo_isqrt.sv
// Pipelined floor square root, one root bit per stage, several lanes in step.
module ikservo_isqrt #(
	parameter int LANES = 2,
	parameter int IW = 60,
	parameter int SBW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [LANES-1:0][IW-1:0] in_op,
	input logic [SBW-1:0] in_sb,
	output logic out_valid,
	output logic [LANES-1:0][IW/2-1:0] out_root,
	output logic [SBW-1:0] out_sb
);

	localparam int K = IW / 2;
	localparam int RW = K + 2;

	logic [LANES-1:0][IW-1:0] op_s [0:K-1];
	logic [LANES-1:0][RW-1:0] rem_s [0:K-1];
	logic [LANES-1:0][K-1:0] root_s [0:K];
	logic v_s [0:K];
	logic [SBW-1:0] sb_s [0:K];

	assign op_s[0] = in_op;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign v_s[0] = in_valid;
	assign sb_s[0] = in_sb;

	for (genvar k = 0; k < K; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sb_s[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [RW-1:0] rn, tr;
			logic ge;

			assign rn = {rem_s[k][l][RW-3:0], op_s[k][l][IW-1 -: 2]};
			assign tr = {root_s[k][l], 2'b01};
			assign ge = rn >= tr;

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[k+1][l] <= {root_s[k][l][K-2:0], ge};
				end
			end

			if (k < K - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k+1][l] <= ge ? rn - tr : rn;
						op_s[k+1][l] <= op_s[k][l] << 2;
					end
				end
			end
		end
	end

	assign out_valid = v_s[K];
	assign out_root = root_s[K];
	assign out_sb = sb_s[K];

endmodule

FILE: hdl/ikservo_cordic.sv
// Pipelined vectoring CORDIC giving atan2 in degrees, several lanes in step.
module ikservo_cordic
	import ikservo_pkg::*;
#(
	parameter int LANES = 3,
	parameter int IW = 34,
	parameter int FRAC = FRAC_BITS_DEF,
	parameter int SBW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [LANES-1:0][IW-1:0] in_x,
	input logic [LANES-1:0][IW-1:0] in_y,
	input logic [SBW-1:0] in_sb,
	output logic out_valid,
	output logic [LANES-1:0][FRAC+10:0] out_z,
	output logic [SBW-1:0] out_sb
);

	localparam int DW = NORM_BITS + 6;
	localparam int ZW = FRAC + 11;
	localparam int NORM = 6;
	localparam int NS = 1 + NORM + CORDIC_STEPS;
	localparam logic signed [ZW-1:0] Z180 = ZW'(180) << FRAC;

	logic [LANES-1:0][DW-1:0] x_s [0:NS-2];
	logic [LANES-1:0][DW-1:0] y_s [0:NS-2];
	logic [LANES-1:0][ZW-1:0] z_s [0:NS-1];
	logic [LANES-1:0][DW-1:0] m_s [0:NORM-1];
	logic v_s [0:NS-1];
	logic [SBW-1:0] sb_s [0:NS-1];

	// fold the left half plane into the right one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= in_sb;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_prep
		logic signed [DW-1:0] xe, ye, xp, yp;
		logic neg;

		assign xe = {{(DW-IW){in_x[l][IW-1]}}, in_x[l]};
		assign ye = {{(DW-IW){in_y[l][IW-1]}}, in_y[l]};
		assign neg = xe[DW-1];
		assign xp = neg ? -xe : xe;
		assign yp = neg ? -ye : ye;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0][l] <= xp;
				y_s[0][l] <= yp;
				z_s[0][l] <= neg ? (ye[DW-1] ? -Z180 : Z180) : '0;
				m_s[0][l] <= xp | (yp[DW-1] ? -yp : yp);
			end
		end
	end

	// scale up until the larger magnitude reaches the normalization bound
	for (genvar j = 0; j < NORM; j++) begin : g_norm
		localparam int SH = 1 << (NORM - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[j+1] <= sb_s[j];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic go;

			assign go = (m_s[j][l] >> (NORM_BITS + 1 - SH)) == '0;

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[j+1][l] <= go ? x_s[j][l] << SH : x_s[j][l];
					y_s[j+1][l] <= go ? y_s[j][l] << SH : y_s[j][l];
					z_s[j+1][l] <= z_s[j][l];
				end
			end

			if (j < NORM - 1) begin : g_mag
				always_ff @(posedge clk) begin
					if (en) begin
						m_s[j+1][l] <= go ? m_s[j][l] << SH : m_s[j][l];
					end
				end
			end
		end
	end

	// one micro-rotation per stage; a zero y holds the vector still
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		localparam int SI = NORM + i;
		localparam logic [63:0] ANG64 = step_angle(i, FRAC);
		localparam logic signed [ZW-1:0] ANG = ANG64[ZW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[SI+1] <= 1'b0;
			end else if (en) begin
				v_s[SI+1] <= v_s[SI];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[SI+1] <= sb_s[SI];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic signed [DW-1:0] xc, yc, dx, dy, xn, yn;
			logic signed [ZW-1:0] zc, zn;

			assign xc = x_s[SI][l];
			assign yc = y_s[SI][l];
			assign zc = z_s[SI][l];
			assign dx = yc[DW-1] ? -((-yc) >>> i) : (yc >>> i);
			assign dy = xc >>> i;

			always_comb begin
				xn = xc;
				yn = yc;
				zn = zc;
				if (yc != '0) begin
					if (!yc[DW-1]) begin
						xn = xc + dx;
						yn = yc - dy;
						zn = zc + ANG;
					end else begin
						xn = xc - dx;
						yn = yc + dy;
						zn = zc - ANG;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					z_s[SI+1][l] <= zn;
				end
			end

			if (i < CORDIC_STEPS - 1) begin : g_vec
				always_ff @(posedge clk) begin
					if (en) begin
						x_s[SI+1][l] <= xn;
						y_s[SI+1][l] <= yn;
					end
				end
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_z = z_s[NS-1];
	assign out_sb = sb_s[NS-1];

endmodule

FILE: hdl/ikservo_back.sv
// Back end: square roots, angle CORDICs, degree truncation and pulse mapping.
module ikservo_back
	import ikservo_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input work_t in_word,
	output logic out_valid,
	input logic out_ready,
	output logic [11:0] joint0_pulse,
	output logic [11:0] joint1_pulse,
	output logic unreachable
);

	localparam int SQ_IW = 60;
	localparam int SQ_K = SQ_IW / 2;
	localparam int CX_W = 34;
	localparam int ZW = FRAC_BITS + 11;
	localparam int DGW = 13;
	localparam int QW = 25;
	localparam int SBW = $bits(side_t);

	logic en;

	logic sq_valid;
	logic [1:0][SQ_IW-1:0] sq_op;
	logic [1:0][SQ_K-1:0] sq_root;
	side_t sq_side;

	logic cx_valid, cx_unr;
	logic [2:0][CX_W-1:0] cx_x, cx_y;
	logic [2:0][ZW-1:0] cx_z;

	logic v_s1, v_s2;
	logic unr_s1, unr_s2;
	logic signed [DGW-1:0] t1_s1, t2_s1;
	logic [1:0] neg_s2;
	logic [1:0][QW-1:0] mag_s2;

	logic [1:0][QW-1:0] q_s [0:QW];
	logic [1:0][9:0] r_s [0:QW-1];
	logic [1:0] neg_s [0:QW];
	logic v_s [0:QW];
	logic unr_s [0:QW];

	logic ov_q, unr_q;
	logic [1:0][11:0] pulse_q;

	logic signed [ZW:0] zsum;
	logic signed [ZW:0] zsum_t;
	logic signed [ZW-1:0] z3_t;
	logic signed [DGW-1:0] t2_w, t3_w;
	logic signed [DGW-1:0] diff;

	assign en = !ov_q || out_ready;
	assign in_ready = en;

	assign sq_op[0] = {in_word.db, 20'b0};
	assign sq_op[1] = {6'b0, in_word.dc, 20'b0};

	ikservo_isqrt #(
		.LANES(2),
		.IW(SQ_IW),
		.SBW(SBW)
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.in_op(sq_op),
		.in_sb(in_word.side),
		.out_valid(sq_valid),
		.out_root(sq_root),
		.out_sb(sq_side)
	);

	// lane 0: asin(y/l) as atan2(y, |x|); lanes 1 and 2: the two acos terms
	assign cx_x[0] = {{(CX_W-8){1'b0}}, sq_side.xabs};
	assign cx_y[0] = {{(CX_W-8){sq_side.y[7]}}, sq_side.y};
	assign cx_x[1] = {sq_side.n[22], sq_side.n, 10'b0};
	assign cx_y[1] = {{(CX_W-SQ_K){1'b0}}, sq_root[0]};
	assign cx_x[2] = {sq_side.m[22], sq_side.m, 10'b0};
	assign cx_y[2] = {{(CX_W-SQ_K){1'b0}}, sq_root[1]};

	ikservo_cordic #(
		.LANES(3),
		.IW(CX_W),
		.FRAC(FRAC_BITS),
		.SBW(1)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sq_valid),
		.in_x(cx_x),
		.in_y(cx_y),
		.in_sb(sq_side.unreachable),
		.out_valid(cx_valid),
		.out_z(cx_z),
		.out_sb(cx_unr)
	);

	// truncate toward zero to whole degrees
	assign zsum = $signed({cx_z[0][ZW-1], cx_z[0]}) + $signed({cx_z[1][ZW-1], cx_z[1]});
	assign zsum_t = zsum[ZW] ? -((-zsum) >>> FRAC_BITS) : (zsum >>> FRAC_BITS);
	assign z3_t = cx_z[2][ZW-1] ? -((-$signed(cx_z[2])) >>> FRAC_BITS)
		: ($signed(cx_z[2]) >>> FRAC_BITS);
	assign t2_w = zsum_t[DGW-1:0];
	assign t3_w = z3_t[DGW-1:0];
	assign diff = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= cx_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unr_s1 <= cx_unr;
			t2_s1 <= t2_w;
			t1_s1 <= DGW'(180) - t2_w - t3_w;
			unr_s2 <= unr_s1;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_prod
		logic signed [2*DGW-1:0] prod;
		logic signed [2*DGW-1:0] pmag;

		assign prod = (l == 0 ? t1_s1 : t2_s1) * diff;
		assign pmag = prod[2*DGW-1] ? -prod : prod;

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s2[l] <= prod[2*DGW-1];
				mag_s2[l] <= pmag[QW-1:0];
			end
		end
	end

	// restoring divide by angle_span, one quotient bit per stage
	assign q_s[0] = mag_s2;
	assign r_s[0] = '0;
	assign neg_s[0] = neg_s2;
	assign v_s[0] = v_s2;
	assign unr_s[0] = unr_s2;

	for (genvar d = 0; d < QW; d++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[d+1] <= 1'b0;
			end else if (en) begin
				v_s[d+1] <= v_s[d];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[d+1] <= neg_s[d];
				unr_s[d+1] <= unr_s[d];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [9:0] rn;
			logic ge;

			assign rn = {r_s[d][l][8:0], q_s[d][l][QW-1]};
			assign ge = rn >= {1'b0, cfg.angle_span};

			always_ff @(posedge clk) begin
				if (en) begin
					q_s[d+1][l] <= {q_s[d][l][QW-2:0], ge};
				end
			end

			if (d < QW - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						r_s[d+1][l] <= ge ? rn - {1'b0, cfg.angle_span} : rn;
					end
				end
			end
		end
	end

	// sign, offset, saturate into the output register
	for (genvar l = 0; l < 2; l++) begin : g_out
		logic signed [QW:0] qs;
		logic signed [QW+1:0] p;
		logic [11:0] sat;

		assign qs = neg_s[QW][l] ? -$signed({1'b0, q_s[QW][l]}) : $signed({1'b0, q_s[QW][l]});
		assign p = (cfg.angle_span == '0) ? $signed({{(QW-10){1'b0}}, cfg.pulse_min})
			: qs + $signed({{(QW-10){1'b0}}, cfg.pulse_min});

		always_comb begin
			if (p[QW+1]) begin
				sat = '0;
			end else if (p > $signed((QW+2)'(4095))) begin
				sat = 12'hfff;
			end else begin
				sat = p[11:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pulse_q[l] <= unr_s[QW] ? '0 : sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unr_q <= unr_s[QW];
		end
	end

	assign out_valid = ov_q;
	assign joint0_pulse = pulse_q[0];
	assign joint1_pulse = pulse_q[1];
	assign unreachable = unr_q;

endmodule

FILE: hdl/two_link_arm_ik_to_servo_pulse_unit.sv
// Top level: two-link planar IK from a target point to two servo pulse counts.
//
// Usage:
//  - Input stream (s_tvalid/s_tready/s_tdata) carries one target point per word:
//    target_x in bits [7:0], target_y in bits [15:8], both signed whole units.
//  - Output stream (m_tvalid/m_tready/m_tdata/m_tuser) returns one word per target:
//    joint0_pulse in [11:0], joint1_pulse in [23:12]; m_tuser flags a target that
//    is at the origin or out of reach, or a zero link length (pulses read zero then).
//  - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes pulse
//    limits, angle span and link lengths; cfg_ready is always high. Write it only
//    while no word is in flight. Indexes above four are dropped.
//  - Throughput: one word per cycle while the receiver keeps m_tready high. A word
//    passes the 4-stage front end, the queue, the 30-stage square root, the
//    39-stage CORDIC, the product registers and the 25-stage pulse divider.
//  - A stalled receiver freezes the back end; the front end keeps accepting until
//    the four-word queue and its own last stage are full, then drops s_tready.
//  - Reset clears all valid flags and loads the register defaults.
module two_link_arm_ik_to_servo_pulse_unit
	import ikservo_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata,   // [7:0] target_x, [15:8] target_y
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata,  // [11:0] joint0_pulse, [23:12] joint1_pulse
	output logic m_tuser,         // [0] unreachable
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [11:0] cfg_data
);

	cfg_t cfg_q;

	logic fr_valid, fr_ready;
	work_t fr_word;
	logic bk_valid, bk_ready;
	work_t bk_word;
	logic [11:0] joint0, joint1;

	// configuration registers, taken on every handshake
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min <= 12'd102;
			cfg_q.pulse_max <= 12'd512;
			cfg_q.angle_span <= 9'd300;
			cfg_q.upper_link_length <= 8'd171;
			cfg_q.lower_link_length <= 8'd192;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PULSE_MIN: cfg_q.pulse_min <= cfg_data;
				REG_PULSE_MAX: cfg_q.pulse_max <= cfg_data;
				REG_ANGLE_SPAN: cfg_q.angle_span <= cfg_data[8:0];
				REG_UPPER_LEN: cfg_q.upper_link_length <= cfg_data[7:0];
				REG_LOWER_LEN: cfg_q.lower_link_length <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// front end: squares, discriminants, reach check
	ikservo_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.target_x(s_tdata[7:0]),
		.target_y(s_tdata[15:8]),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_word(fr_word)
	);

	// decouple the two halves so each can stall on its own
	ikservo_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fr_valid),
		.in_ready(fr_ready),
		.in_word(fr_word),
		.out_valid(bk_valid),
		.out_ready(bk_ready),
		.out_word(bk_word)
	);

	// back end: roots, angles, pulse mapping, output register
	ikservo_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(bk_valid),
		.in_ready(bk_ready),
		.in_word(bk_word),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.joint0_pulse(joint0),
		.joint1_pulse(joint1),
		.unreachable(m_tuser)
	);

	assign m_tdata = {joint1, joint0};

endmodule
